// ===== sv/wodo_pkg.sv =====
// Shared types and constants for the wheel encoder speed and odometry block.
package wodo_pkg;

    // Command codes carried in tuser
    localparam logic [1:0] CMD_EDGE   = 2'd0;
    localparam logic [1:0] CMD_SAMPLE = 2'd1;
    localparam logic [1:0] CMD_RESET  = 2'd2;
    localparam logic [1:0] CMD_SPARE  = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [1:0] CFG_STALL    = 2'd1;
    localparam logic [1:0] CFG_UM_TICK  = 2'd2;

    // Configuration reset values
    localparam logic [15:0] DEBOUNCE_RST = 16'd50;
    localparam logic [31:0] STALL_RST    = 32'd100000;
    localparam logic [15:0] UM_TICK_RST  = 16'd100;

    // Divider geometry: left-justified dividend, two quotient bits per cycle
    localparam int DVD_W = 48;
    localparam int DVS_W = 32;
    localparam int CNT_W = 5;
    localparam int MAG_W = 26;
    localparam int DIST_W = 39;
    localparam int SPEED_W = 27;
    localparam logic [CNT_W-1:0] DIST_STEPS  = CNT_W'(DVD_W / 2);
    localparam logic [CNT_W-1:0] SPEED_STEPS = CNT_W'(MAG_W / 2);
    localparam logic [DVS_W-1:0] MM_SCALE    = 32'd1000;

    typedef struct packed {
        logic              start;
        logic [DVD_W-1:0]  dividend;
        logic [DVS_W-1:0]  divisor;
        logic [CNT_W-1:0]  steps;
    } t_div_req;

    typedef struct packed {
        logic [31:0] count;
        logic [31:0] last;
        logic [31:0] gap;
        logic [31:0] base;
        logic        rev;
    } t_wheel_rd;

    typedef struct packed {
        logic        edge_we;
        logic        base_all;
        logic [31:0] now;
        logic [31:0] gap;
        logic        rev;
    } t_wheel_wr;

endpackage

// ===== sv/wheel_encoder_speed_odometry_top.sv =====
// Top level: encoder edge debounce, period speed and odometry sequencer.
//
//  channel | dir | payload
//  --------+-----+-----------------------------------------------------------
//  s_axis  | in  | tuser: command[1:0], side[2]; tdata: timestamp_us[31:0],
//          |     |   b_level[32], zero pad to 40 bits
//  m_axis  | out | tdata: accepted, reverse, edge_total, effective_period_us,
//          |     |   speed_mm_s, distance_mm (see port), zero pad to 136 bits
//  cfg     | in  | i_cfg_we / i_cfg_index / i_cfg_wdata, write only
//
// Sequence: an edge, reset or unused command goes from the load step straight
// to the done state. A sample runs the load step, then distance / 1000 (24
// divider steps) and um_per_tick*1000 / period (13 steps), both on the one
// shared divider (two quotient bits a cycle), then goes into the output
// register; a zero period skips the second division.
// Input tready is high only while the sequencer is idle; one finished item
// may wait in the output register while the next item is taken in, and a
// further result stalls the sequencer until the output register frees up.
// Synchronous active-low reset clears wheel state and loads config defaults.
module wheel_encoder_speed_odometry_top #(
    parameter int NUM_WHEELS = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    // stream in
    input  logic           i_s_axis_tvalid,
    output logic           o_s_axis_tready,
    input  logic [39:0]    i_s_axis_tdata,  // timestamp_us[31:0], b_level[32]
    input  logic [2:0]     i_s_axis_tuser,  // command[1:0], side[2]
    // stream out
    output logic           o_m_axis_tvalid,
    input  logic           i_m_axis_tready,
    // accepted[0], reverse[1], edge_total[33:2], effective_period_us[65:34],
    // speed_mm_s[92:66], distance_mm[131:93]
    output logic [135:0]   o_m_axis_tdata,
    // configuration
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_index,
    input  logic [31:0]    i_cfg_wdata
);

    localparam int IDX_W = (NUM_WHEELS > 1) ? $clog2(NUM_WHEELS) : 1;
    localparam int PAD_W = wodo_pkg::DVD_W - wodo_pkg::MAG_W;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_LOAD  = 5'b00010,
        ST_DIST  = 5'b00100,
        ST_SPEED = 5'b01000,
        ST_DONE  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // configuration registers
    logic [15:0] r_debounce;
    logic [31:0] r_stall;
    logic [15:0] r_um;

    // latched item
    logic [1:0]  r_cmd;
    logic        r_side;
    logic [31:0] r_now;
    logic        r_blev;

    // per-item results
    logic                         r_acc;
    logic [31:0]                  r_period;
    logic [wodo_pkg::DIST_W-1:0]  r_dist;
    logic [wodo_pkg::MAG_W-1:0]   r_mag;

    logic         r_out_valid;
    logic [135:0] r_out_data;
    logic [135:0] n_out_data;

    logic [IDX_W-1:0]     idx;
    logic                 side_ok;
    wodo_pkg::t_wheel_rd  rd;
    wodo_pkg::t_wheel_wr  wr;
    wodo_pkg::t_div_req   div_req;
    logic                 div_done;
    logic [wodo_pkg::DVD_W-1:0] div_quot;

    logic [31:0] since;
    logic        deb_ok;
    logic [31:0] period_sel;
    logic [31:0] ticks;
    logic [47:0] dist_prod;
    logic [wodo_pkg::MAG_W-1:0] speed_num;
    logic        is_sample;
    logic        out_free;
    logic [wodo_pkg::SPEED_W-1:0] speed;

    assign idx     = IDX_W'(r_side);
    assign side_ok = 32'(r_side) < NUM_WHEELS;
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign is_sample = (r_cmd == wodo_pkg::CMD_SAMPLE) && side_ok;

    wodo_bank #(
        .NUM_WHEELS (NUM_WHEELS),
        .IDX_W      (IDX_W)
    ) u_bank (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_idx   (idx),
        .i_wr    (wr),
        .o_rd    (rd)
    );

    wodo_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Time since the last accepted edge, wrapping
    always_comb begin
        since  = r_now - rd.last;
        deb_ok = since >= {16'b0, r_debounce};
        if ((rd.gap == '0) || (since > r_stall)) begin
            period_sel = '0;
        end else begin
            period_sel = (since > rd.gap) ? since : rd.gap;
        end
        ticks     = rd.count - rd.base;
        dist_prod = 48'(ticks) * 48'(r_um);
        speed_num = wodo_pkg::MAG_W'(32'(r_um) * wodo_pkg::MM_SCALE);
    end

    // State updates happen at the end of the load cycle
    always_comb begin
        wr.edge_we  = (r_state == ST_LOAD) && (r_cmd == wodo_pkg::CMD_EDGE)
                      && side_ok && deb_ok;
        wr.base_all = (r_state == ST_LOAD) && (r_cmd == wodo_pkg::CMD_RESET);
        wr.now      = r_now;
        wr.gap      = since;
        wr.rev      = r_blev;
    end

    // Divider requests: distance first, then speed
    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = dist_prod;
        div_req.divisor  = wodo_pkg::MM_SCALE;
        div_req.steps    = wodo_pkg::DIST_STEPS;
        if ((r_state == ST_LOAD) && is_sample) begin
            div_req.start = 1'b1;
        end else if ((r_state == ST_DIST) && div_done && (r_period != '0)) begin
            div_req.start    = 1'b1;
            div_req.dividend = {speed_num, PAD_W'(0)};
            div_req.divisor  = r_period;
            div_req.steps    = wodo_pkg::SPEED_STEPS;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_axis_tvalid) n_state = ST_LOAD;
            end
            ST_LOAD: begin
                n_state = is_sample ? ST_DIST : ST_DONE;
            end
            ST_DIST: begin
                if (div_done) n_state = (r_period != '0) ? ST_SPEED : ST_DONE;
            end
            ST_SPEED: begin
                if (div_done) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= wodo_pkg::DEBOUNCE_RST;
            r_stall    <= wodo_pkg::STALL_RST;
            r_um       <= wodo_pkg::UM_TICK_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                wodo_pkg::CFG_DEBOUNCE: r_debounce <= i_cfg_wdata[15:0];
                wodo_pkg::CFG_STALL:    r_stall    <= i_cfg_wdata;
                wodo_pkg::CFG_UM_TICK:  r_um       <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // Item latch and working results
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_IDLE) && i_s_axis_tvalid) begin
            r_cmd  <= i_s_axis_tuser[1:0];
            r_side <= i_s_axis_tuser[2];
            r_now  <= i_s_axis_tdata[31:0];
            r_blev <= i_s_axis_tdata[32];
        end
        if (r_state == ST_LOAD) begin
            r_acc    <= wr.edge_we;
            r_period <= is_sample ? period_sel : '0;
            r_dist   <= '0;
            r_mag    <= '0;
        end
        if ((r_state == ST_DIST) && div_done) begin
            r_dist <= wodo_pkg::DIST_W'(div_quot);
        end
        if ((r_state == ST_SPEED) && div_done) begin
            r_mag <= div_quot[wodo_pkg::MAG_W-1:0];
        end
    end

    // Signed speed: negate magnitude when running in reverse
    assign speed = rd.rev ? wodo_pkg::SPEED_W'(-{1'b0, r_mag})
                          : wodo_pkg::SPEED_W'({1'b0, r_mag});

    // Result word; unused command or absent wheel leaves every field zero
    always_comb begin
        n_out_data = '0;
        if (side_ok && (r_cmd != wodo_pkg::CMD_SPARE)) begin
            n_out_data[0]    = r_acc;
            n_out_data[1]    = rd.rev;
            n_out_data[33:2] = rd.count;
            if (is_sample) begin
                n_out_data[65:34]  = r_period;
                n_out_data[92:66]  = speed;
                n_out_data[131:93] = r_dist;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_DONE) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_DONE) && out_free) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

// ===== sv/wodo_div.sv =====
// Shared restoring divider, two quotient bits per cycle, left-justified dividend.
module wodo_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  wodo_pkg::t_div_req                  i_req,
    output logic                                o_done,
    output logic [wodo_pkg::DVD_W-1:0]          o_quot
);

    logic [wodo_pkg::CNT_W-1:0] r_cnt;
    logic [wodo_pkg::DVD_W-1:0] r_dvd;
    logic [wodo_pkg::DVS_W-1:0] r_dvs;
    logic [wodo_pkg::DVS_W-1:0] r_rem;
    logic [wodo_pkg::DVD_W-1:0] r_quot;
    logic                       r_done;

    logic [wodo_pkg::DVS_W:0]   rem_a;
    logic [wodo_pkg::DVS_W:0]   rem_b;
    logic [wodo_pkg::DVS_W-1:0] rem_a2;
    logic [wodo_pkg::DVS_W-1:0] n_rem;
    logic                       ge_a;
    logic                       ge_b;

    always_comb begin
        rem_a  = {r_rem, r_dvd[wodo_pkg::DVD_W-1]};
        ge_a   = rem_a >= {1'b0, r_dvs};
        rem_a2 = ge_a ? wodo_pkg::DVS_W'(rem_a - {1'b0, r_dvs})
                      : wodo_pkg::DVS_W'(rem_a);
        rem_b  = {rem_a2, r_dvd[wodo_pkg::DVD_W-2]};
        ge_b   = rem_b >= {1'b0, r_dvs};
        n_rem  = ge_b ? wodo_pkg::DVS_W'(rem_b - {1'b0, r_dvs})
                      : wodo_pkg::DVS_W'(rem_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == wodo_pkg::CNT_W'(1)) && !i_req.start;
            if (i_req.start) begin
                r_cnt <= i_req.steps;
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd  <= i_req.dividend;
            r_dvs  <= i_req.divisor;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_cnt != '0) begin
            r_dvd  <= {r_dvd[wodo_pkg::DVD_W-3:0], 2'b00};
            r_rem  <= n_rem;
            r_quot <= {r_quot[wodo_pkg::DVD_W-3:0], ge_a, ge_b};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== sv/wodo_bank.sv =====
// Per-wheel encoder state: counts, edge times, gaps, baselines, direction.
module wodo_bank #(
    parameter int NUM_WHEELS = 2,
    parameter int IDX_W      = 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [IDX_W-1:0]    i_idx,
    input  wodo_pkg::t_wheel_wr i_wr,
    output wodo_pkg::t_wheel_rd o_rd
);

    logic [31:0] r_count [NUM_WHEELS];
    logic [31:0] r_last  [NUM_WHEELS];
    logic [31:0] r_gap   [NUM_WHEELS];
    logic [31:0] r_base  [NUM_WHEELS];
    logic        r_rev   [NUM_WHEELS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_WHEELS; i++) begin
                r_count[i] <= '0;
                r_last[i]  <= '0;
                r_gap[i]   <= '0;
                r_base[i]  <= '0;
                r_rev[i]   <= 1'b0;
            end
        end else begin
            for (int i = 0; i < NUM_WHEELS; i++) begin
                if (i_wr.base_all) begin
                    r_base[i] <= r_count[i];
                end
                if (i_wr.edge_we && (i_idx == IDX_W'(i))) begin
                    r_count[i] <= r_count[i] + 32'd1;
                    r_last[i]  <= i_wr.now;
                    r_gap[i]   <= i_wr.gap;
                    r_rev[i]   <= i_wr.rev;
                end
            end
        end
    end

    assign o_rd.count = r_count[i_idx];
    assign o_rd.last  = r_last[i_idx];
    assign o_rd.gap   = r_gap[i_idx];
    assign o_rd.base  = r_base[i_idx];
    assign o_rd.rev   = r_rev[i_idx];

endmodule

// ===== sv/wodo_checker.sv =====
// Port-level checker for the encoder block, bound to the top level.
module wodo_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_axis_tvalid,
    input logic         o_s_axis_tready,
    input logic         o_m_axis_tvalid,
    input logic         i_m_axis_tready,
    input logic [135:0] o_m_axis_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
        (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("result changed while stalled");

    // one item at a time: busy right after an accept
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("ready stayed high after accept");

    // reset empties the output and idles the sequencer
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_m_axis_tvalid && o_s_axis_tready))
        else $error("reset did not clear state");

    // an accepted edge never carries sample fields
    a_edge_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[0]) |->
        ((o_m_axis_tdata[65:34] == '0) && (o_m_axis_tdata[131:66] == '0)))
        else $error("edge result with sample fields");

    // speed implies a period
    a_speed_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tdata[92:66] != '0)) |->
        (o_m_axis_tdata[65:34] != '0))
        else $error("speed without period");

endmodule

bind wheel_encoder_speed_odometry_top wodo_checker u_wodo_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench for the wheel encoder speed and odometry block.
module tb_top;
    import wodo_pkg::*;

    localparam int WHEELS      = 2;
    localparam int HALF_PERIOD = 10;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 50;     // well past the sample latency

    // One encoder command as it travels on the input stream
    typedef struct packed {
        logic [1:0]  cmd;
        logic        side;
        logic [31:0] stamp;
        logic        blev;
    } t_enc_item;

    // One report, declared from the top bit down so it overlays tdata[131:0]
    typedef struct packed {
        logic [38:0] distance;
        logic [26:0] speed;
        logic [31:0] period;
        logic [31:0] edges;
        logic        rev;
        logic        accepted;
    } t_odo_report;

    logic         clk       = 1'b0;
    logic         rst_n     = 1'b0;
    logic         in_valid  = 1'b0;
    logic         in_ready;
    logic [39:0]  in_data   = '0;
    logic [2:0]   in_user   = '0;
    logic         out_valid;
    logic         out_ready = 1'b0;
    logic [135:0] out_data;
    logic         cfg_we    = 1'b0;
    logic [1:0]   cfg_index = '0;
    logic [31:0]  cfg_wdata = '0;

    wheel_encoder_speed_odometry_top #(
        .NUM_WHEELS (WHEELS)
    ) u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (in_valid),
        .o_s_axis_tready (in_ready),
        .i_s_axis_tdata  (in_data),
        .i_s_axis_tuser  (in_user),
        .o_m_axis_tvalid (out_valid),
        .i_m_axis_tready (out_ready),
        .o_m_axis_tdata  (out_data),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_wdata     (cfg_wdata)
    );

    always #HALF_PERIOD clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor state: per-wheel encoder bookkeeping plus a register copy
    // ------------------------------------------------------------------
    logic [31:0] wh_count [WHEELS];
    logic [31:0] wh_last  [WHEELS];
    logic [31:0] wh_gap   [WHEELS];
    logic [31:0] wh_base  [WHEELS];
    logic        wh_rev   [WHEELS];
    logic [15:0] debounce_cfg;
    logic [31:0] stall_cfg;
    logic [15:0] um_tick_cfg;

    t_enc_item   enc_pending [$];   // commands waiting to be offered
    t_odo_report reports_due [$];   // predicted reports, oldest first

    int       errors     = 0;
    int       cycles     = 0;
    int       send_idle  = 0;       // percent of cycles the sender holds back
    int       recv_idle  = 0;       // percent of cycles the receiver stalls
    logic     send_hold  = 1'b0;
    logic     s_took     = 1'b0;    // input item taken at the last rising edge
    int       hold_asks  = 0;
    int       hold_seen  = 0;
    int       hold_left  = 0;
    logic [31:0] now_us;            // running microsecond clock for stimulus
    logic     dir_bit [WHEELS];

    // Works out the report for one command and moves the wheel state on.
    function automatic t_odo_report predict_report(t_enc_item it);
        t_odo_report r;
        logic [31:0] since, period, ticks, mag;
        logic [47:0] prod;
        int w, i;
        r = '0;
        w = it.side;
        // a baseline reset moves every wheel, whichever side was addressed
        if (it.cmd == CMD_RESET) begin
            for (i = 0; i < WHEELS; i++)
                wh_base[i] = wh_count[i];
        end
        // unused code, answered with zeros
        if (it.cmd == CMD_SPARE)
            return r;
        since = it.stamp - wh_last[w];    // wraps mod 2^32
        if (it.cmd == CMD_EDGE) begin
            if (since >= {16'd0, debounce_cfg}) begin
                wh_rev[w]   = it.blev;
                wh_last[w]  = it.stamp;
                wh_gap[w]   = since;
                wh_count[w] = wh_count[w] + 32'd1;
                r.accepted  = 1'b1;
            end
        end else if (it.cmd == CMD_SAMPLE) begin
            // no period yet, or quiet for too long: wheel counts as stopped
            if (wh_gap[w] == 32'd0 || since > stall_cfg)
                period = 32'd0;
            else
                period = (since > wh_gap[w]) ? since : wh_gap[w];
            ticks  = wh_count[w] - wh_base[w];
            prod   = {16'd0, ticks} * {32'd0, um_tick_cfg};
            r.distance = 39'(prod / 48'd1000);
            mag    = (period == 32'd0) ? 32'd0 : ({16'd0, um_tick_cfg} * 32'd1000) / period;
            r.speed  = wh_rev[w] ? 27'(32'd0 - mag) : 27'(mag);
            r.period = period;
        end
        r.rev   = wh_rev[w];
        r.edges = wh_count[w];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Monitor: predicts on each input item taken, checks each report
    // ------------------------------------------------------------------
    always @(posedge clk) begin : watch_streams
        t_odo_report want, got;
        s_took = 1'b0;
        if (rst_n && in_valid && in_ready) begin
            reports_due.push_back(predict_report(
                '{cmd: in_user[1:0], side: in_user[2], stamp: in_data[31:0], blev: in_data[32]}));
            s_took = 1'b1;
        end
        if (rst_n && out_valid && out_ready) begin
            got = t_odo_report'(out_data[131:0]);
            if (reports_due.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected report: acc=%0d rev=%0d edges=%0d",
                             got.accepted, got.rev, got.edges);
            end else begin
                want = reports_due.pop_front();
                if (got.accepted !== want.accepted || got.rev !== want.rev ||
                    got.edges !== want.edges || got.period !== want.period ||
                    got.speed !== want.speed || got.distance !== want.distance) begin
                    errors++;
                    if (errors <= 10)
                        $display("report mismatch: exp acc=%0d rev=%0d edges=%0d per=%0d ",
                                 want.accepted, want.rev, want.edges, want.period,
                                 "spd=%0d dist=%0d | got acc=%0d rev=%0d edges=%0d ",
                                 $signed(want.speed), want.distance,
                                 got.accepted, got.rev, got.edges,
                                 "per=%0d spd=%0d dist=%0d",
                                 got.period, $signed(got.speed), got.distance);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: offers the next pending item once the current one is taken
    // ------------------------------------------------------------------
    always @(negedge clk) begin : drive_commands
        t_enc_item nxt;
        if (rst_n && (!in_valid || s_took)) begin
            if (!send_hold && enc_pending.size() != 0 && $urandom_range(99) >= send_idle) begin
                nxt = enc_pending.pop_front();
                in_user  <= {nxt.side, nxt.cmd};
                in_data  <= {7'd0, nxt.blev, nxt.stamp};
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request so the
    // block backs up and drops its input ready while items keep coming
    always @(negedge clk) begin
        if (hold_asks != hold_seen) begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= rst_n && ($urandom_range(99) >= recv_idle);
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_item(input logic [1:0] cmd, input logic side,
                             input logic [31:0] stamp, input logic blev);
        enc_pending.push_back('{cmd: cmd, side: side, stamp: stamp, blev: blev});
    endtask

    // Waits until nothing is queued, offered or outstanding, then lets the
    // divider finish anything still in flight.
    task automatic wait_idle();
        while (enc_pending.size() != 0 || in_valid || reports_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_DEBOUNCE: debounce_cfg = val[15:0];
            CFG_STALL:    stall_cfg    = val;
            CFG_UM_TICK:  um_tick_cfg  = val[15:0];
            default: ;
        endcase
    endtask

    // New phase: drain, pick the idling mix, load all three registers.
    task automatic start_phase(input int s_idle, input int r_idle, input logic [15:0] deb,
                               input logic [31:0] stall, input logic [15:0] um);
        wait_idle();
        send_idle = s_idle;
        recv_idle = r_idle;
        cfg_write(CFG_DEBOUNCE, {16'd0, deb});
        cfg_write(CFG_STALL, stall);
        cfg_write(CFG_UM_TICK, {16'd0, um});
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Mostly realistic edge trains on a shared running clock: spacing near
    // or above debounce, some bounces, some long quiet spells, the odd
    // wild jump, samples at control rate and a little junk.
    task automatic queue_random(input int n);
        t_enc_item it;
        int r;
        logic [31:0] adv;
        repeat (n) begin
            r = $urandom_range(99);
            it.side = $urandom_range(1);
            if (r < 55)      it.cmd = CMD_EDGE;
            else if (r < 88) it.cmd = CMD_SAMPLE;
            else if (r < 97) it.cmd = CMD_RESET;
            else             it.cmd = CMD_SPARE;
            if ($urandom_range(9) == 0)
                dir_bit[it.side] = ~dir_bit[it.side];
            it.blev = dir_bit[it.side];
            r = $urandom_range(99);
            if (it.cmd != CMD_EDGE)
                adv = (r < 30) ? 32'd0 : 32'($urandom_range(400));
            else if (r < 12)
                adv = 32'($urandom_range(debounce_cfg));            // bounce
            else if (r < 18)
                adv = {16'd0, debounce_cfg} - 32'($urandom_range(1)); // at the threshold
            else if (r < 24)
                adv = stall_cfg + 32'($urandom_range(2000));         // beyond stall
            else if (r < 27)
                adv = $urandom();
            else
                adv = {16'd0, debounce_cfg} + 32'($urandom_range(1500));
            now_us   = now_us + adv;
            it.stamp = now_us;
            enc_pending.push_back(it);
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        for (int i = 0; i < WHEELS; i++) begin
            wh_count[i] = '0;
            wh_last[i]  = '0;
            wh_gap[i]   = '0;
            wh_base[i]  = '0;
            wh_rev[i]   = 1'b0;
            dir_bit[i]  = 1'b0;
        end
        debounce_cfg = DEBOUNCE_RST;
        stall_cfg    = STALL_RST;
        um_tick_cfg  = UM_TICK_RST;
        send_idle    = 6;
        recv_idle    = 61;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part on reset defaults (debounce 50, stall 100000, 100 um)
        push_item(CMD_SAMPLE, 1'b0, 32'd0, 1'b0);         // no period yet
        push_item(CMD_EDGE,   1'b0, 32'd10, 1'b0);        // too soon: rejected
        push_item(CMD_EDGE,   1'b0, 32'd50, 1'b0);        // exactly debounce
        push_item(CMD_EDGE,   1'b0, 32'd99, 1'b1);        // one short: rejected
        push_item(CMD_EDGE,   1'b0, 32'd1050, 1'b0);
        push_item(CMD_SAMPLE, 1'b0, 32'd1500, 1'b0);      // gap is the period
        push_item(CMD_SAMPLE, 1'b0, 32'd3000, 1'b0);      // elapsed is longer
        push_item(CMD_SAMPLE, 1'b0, 32'd101051, 1'b0);    // just past stall
        push_item(CMD_EDGE,   1'b1, 32'hFFFF_FFF0, 1'b1);
        push_item(CMD_EDGE,   1'b1, 32'h0000_0020, 1'b1); // wraps, still too soon
        push_item(CMD_EDGE,   1'b1, 32'h0000_0030, 1'b1); // wraps, accepted
        push_item(CMD_SAMPLE, 1'b1, 32'h0000_0040, 1'b0); // reverse speed
        push_item(CMD_RESET,  1'b0, 32'h0000_0041, 1'b0);
        push_item(CMD_SAMPLE, 1'b0, 32'h0000_0050, 1'b1);
        push_item(CMD_EDGE,   1'b0, 32'h0001_0000, 1'b1);
        push_item(CMD_SPARE,  1'b1, 32'hFFFF_FFFF, 1'b1);
        push_item(CMD_SPARE,  1'b0, 32'h0000_0000, 1'b0);
        push_item(CMD_RESET,  1'b1, 32'h0001_0001, 1'b1);
        push_item(CMD_SAMPLE, 1'b1, 32'hFFFF_FFFF, 1'b1); // long quiet on right
        push_item(CMD_EDGE,   1'b1, 32'hFFFF_FFFF, 1'b0);
        push_item(CMD_SAMPLE, 1'b1, 32'hFFFF_FFFF, 1'b0); // zero elapsed time
        push_item(CMD_SAMPLE, 1'b0, 32'h0001_0100, 1'b0);

        // No debounce, never stalls, largest tick: top speed and distance
        start_phase(6, 61, 16'd0, 32'hFFFF_FFFF, 16'hFFFF);
        now_us = 32'hFFFF_F000;   // crosses the wrap early on
        queue_random(250);

        // Largest debounce, zero stall timeout, smallest tick
        start_phase(61, 6, 16'hFFFF, 32'd0, 16'd1);
        now_us = $urandom();
        queue_random(150);

        // Mid-range settings; the sender stops halfway until all reports are in
        start_phase(61, 6, 16'd200, 32'd5000, 16'd250);
        queue_random(250);
        while (enc_pending.size() > 125)
            @(posedge clk);
        send_hold = 1'b1;
        while (in_valid || reports_due.size() != 0)
            @(posedge clk);
        send_hold = 1'b0;

        // Typical settings, no idling, one long receiver hold-off up front
        start_phase(0, 0, 16'd20, 32'd100000, 16'd100);
        @(posedge clk);
        hold_asks++;
        queue_random(280);

        wait_idle();
        if (errors == 0 && reports_due.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/wodo_pkg.sv
sv/wodo_div.sv
sv/wodo_bank.sv
sv/wheel_encoder_speed_odometry_top.sv
sv/wodo_checker.sv
tb/tb_top.sv
